### rtl/deq_pkg.sv
// Package for the double-ended queue core: sizes, command and status codes,
// and index wrap helpers. It has no dependencies.
package deq_pkg;

  localparam int Depth     = 64;
  localparam int IdxBits   = $clog2(Depth);
  localparam int CountBits = 7;
  localparam int WordBits  = 32;

  localparam logic [1:0] CmdPushBack  = 2'd0;
  localparam logic [1:0] CmdPopBack   = 2'd1;
  localparam logic [1:0] CmdPushFront = 2'd2;
  localparam logic [1:0] CmdPopFront  = 2'd3;

  localparam logic [1:0] StatOk        = 2'd0;
  localparam logic [1:0] StatOverflow  = 2'd1;
  localparam logic [1:0] StatUnderflow = 2'd2;

  localparam logic [IdxBits-1:0]   LastIdx   = IdxBits'(Depth - 1);
  localparam logic [CountBits-1:0] FullCount = CountBits'(Depth);

  function automatic logic [IdxBits-1:0] idx_next(input logic [IdxBits-1:0] i);
    return (i == LastIdx) ? '0 : i + IdxBits'(1);
  endfunction

  function automatic logic [IdxBits-1:0] idx_prev(input logic [IdxBits-1:0] i);
    return (i == '0) ? LastIdx : i - IdxBits'(1);
  endfunction

endpackage

### rtl/double_ended_queue_core.sv
// Double-ended queue of signed words kept in a circular buffer memory.
// Depends on deq_pkg for sizes, codes and index helpers.
//
// Usage: each request on the slave stream carries a command in tuser
// (push back, pop back, push front, pop front) and a word in tdata that
// pushes store. Every request yields exactly one response on the master
// stream with a status in tuser and the popped word, the front and back
// words, the entry count and an empty flag in tdata.
// When a request is taken, the memory read for the word that becomes the new
// end after a pop is issued; in the execute state the update is applied and
// the response register is loaded once the output register is free. A new
// request is not taken until the previous one has reached the response
// register.
// A response that waits in the output register does not block acceptance
// of the next request; that request holds in the execute state until the
// output register is free.
// Reset empties the queue at once; memory contents are not cleared, and a word
// that was never written never reaches a response.
module double_ended_queue_core
  import deq_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [31:0]  s_axis_tdata_i,   // [31:0] push_value
  input  logic [1:0]   s_axis_tuser_i,   // [1:0] command
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [103:0] m_axis_tdata_o,   // [31:0] popped_value, [63:32] front_value,
                                         // [95:64] back_value, [102:96] entry_count,
                                         // [103] is_empty
  output logic [1:0]   m_axis_tuser_o    // [1:0] status
);

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic [WordBits-1:0] mem_q [Depth];

  logic                 state_q, state_d;
  logic [IdxBits-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CountBits-1:0] count_q, count_d;
  logic [WordBits-1:0]  front_q, front_d, back_q, back_d;
  logic [1:0]           cmd_q;
  logic [WordBits-1:0]  val_q;
  logic [WordBits-1:0]  rdata_q;
  logic                 out_valid_q;
  logic [103:0]         out_data_q;
  logic [1:0]           out_user_q;

  logic                 accept;
  logic                 out_free;
  logic                 commit;
  logic [IdxBits-1:0]   raddr;
  logic                 wr_en;
  logic [IdxBits-1:0]   waddr;
  logic [1:0]           status;
  logic [WordBits-1:0]  popped;
  logic [103:0]         resp_data;

  assign s_axis_tready_o = (state_q == StIdle);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign commit          = (state_q == StExec) && out_free;

  always_comb begin
    if (s_axis_tuser_i == CmdPopBack) begin
      raddr = idx_prev(idx_prev(tail_q));
    end else begin
      raddr = idx_next(head_q);
    end
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    front_d = front_q;
    back_d  = back_q;
    status  = StatOk;
    popped  = '0;
    wr_en   = 1'b0;
    waddr   = tail_q;
    unique case (cmd_q)
      CmdPushBack, CmdPushFront: begin
        if (count_q == FullCount) begin
          status = StatOverflow;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + CountBits'(1);
          if (cmd_q == CmdPushBack) begin
            waddr  = tail_q;
            tail_d = idx_next(tail_q);
            back_d = val_q;
            if (count_q == '0) begin
              front_d = val_q;
            end
          end else begin
            waddr   = idx_prev(head_q);
            head_d  = idx_prev(head_q);
            front_d = val_q;
            if (count_q == '0) begin
              back_d = val_q;
            end
          end
        end
      end
      default: begin
        if (count_q == '0) begin
          status = StatUnderflow;
        end else begin
          count_d = count_q - CountBits'(1);
          if (cmd_q == CmdPopBack) begin
            popped = back_q;
            tail_d = idx_prev(tail_q);
            back_d = rdata_q;
          end else begin
            popped  = front_q;
            head_d  = idx_next(head_q);
            front_d = rdata_q;
          end
        end
      end
    endcase
  end

  always_comb begin
    resp_data          = '0;
    resp_data[31:0]    = popped;
    resp_data[102:96]  = count_d;
    resp_data[103]     = (count_d == '0);
    if (count_d != '0) begin
      resp_data[63:32] = front_d;
      resp_data[95:64] = back_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StExec;
        end
      end
      default: begin
        if (commit) begin
          state_d = StIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (commit && wr_en) begin
      mem_q[waddr] <= val_q;
    end
    if (accept) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= s_axis_tuser_i;
      val_q <= s_axis_tdata_i;
    end
    if (commit) begin
      front_q    <= front_d;
      back_q     <= back_d;
      out_data_q <= resp_data;
      out_user_q <= status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        head_q      <= head_d;
        tail_q      <= tail_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

### verif/double_ended_queue_checker.sv
// Response checker for double_ended_queue_core: watches the request and
// response streams, keeps its own copy of the queue and compares each response.
// Depends on deq_pkg for sizes, command codes and status codes.
module double_ended_queue_checker
  import deq_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         req_valid_i,
  input  logic         req_ready_i,
  input  logic [31:0]  req_data_i,   // [31:0] push_value
  input  logic [1:0]   req_user_i,   // [1:0] command
  input  logic         rsp_valid_i,
  input  logic         rsp_ready_i,
  input  logic [103:0] rsp_data_i,   // [31:0] popped_value, [63:32] front_value,
                                     // [95:64] back_value, [102:96] entry_count,
                                     // [103] is_empty
  input  logic [1:0]   rsp_user_i,   // [1:0] status
  output int           mismatches_o,
  output int           outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]           status;
    logic [31:0]          popped_value;
    logic [31:0]          front_value;
    logic [31:0]          back_value;
    logic [CountBits-1:0] entry_count;
    logic                 is_empty;
  } deq_response_t;

  logic [WordBits-1:0]  words [Depth];
  logic [IdxBits-1:0]   head_idx;
  logic [IdxBits-1:0]   tail_idx;
  logic [CountBits-1:0] held;
  deq_response_t        awaited_q[$];
  deq_response_t        predicted;

  task automatic apply_request(input logic [1:0] cmd, input logic [31:0] word,
                               output deq_response_t rsp);
    rsp = '0;
    rsp.status = StatOk;
    case (cmd)
      CmdPushBack: begin
        if (held == FullCount) begin
          rsp.status = StatOverflow;
        end else begin
          words[tail_idx] = word;
          tail_idx = tail_idx + IdxBits'(1);
          held = held + CountBits'(1);
        end
      end
      CmdPushFront: begin
        if (held == FullCount) begin
          rsp.status = StatOverflow;
        end else begin
          head_idx = head_idx - IdxBits'(1);
          words[head_idx] = word;
          held = held + CountBits'(1);
        end
      end
      CmdPopBack: begin
        if (held == '0) begin
          rsp.status = StatUnderflow;
        end else begin
          tail_idx = tail_idx - IdxBits'(1);
          rsp.popped_value = words[tail_idx];
          held = held - CountBits'(1);
        end
      end
      CmdPopFront: begin
        if (held == '0) begin
          rsp.status = StatUnderflow;
        end else begin
          rsp.popped_value = words[head_idx];
          head_idx = head_idx + IdxBits'(1);
          held = held - CountBits'(1);
        end
      end
      default: begin
      end
    endcase
    if (held != '0) begin
      rsp.front_value = words[head_idx];
      rsp.back_value  = words[tail_idx - IdxBits'(1)];
    end
    rsp.entry_count = held;
    rsp.is_empty    = (held == '0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches_o++;
    end
  endtask

  task automatic compare_response(input deq_response_t want);
    check_field("status", 32'(want.status), 32'(rsp_user_i));
    check_field("popped_value", want.popped_value, rsp_data_i[31:0]);
    check_field("front_value", want.front_value, rsp_data_i[63:32]);
    check_field("back_value", want.back_value, rsp_data_i[95:64]);
    check_field("entry_count", 32'(want.entry_count), 32'(rsp_data_i[102:96]));
    check_field("is_empty", 32'(want.is_empty), 32'(rsp_data_i[103]));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_idx = '0;
      tail_idx = '0;
      held = '0;
      awaited_q.delete();
      mismatches_o = 0;
      outstanding_o = 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (awaited_q.size() == 0) begin
          $error("response arrived with no request outstanding");
          mismatches_o++;
        end else begin
          compare_response(awaited_q.pop_front());
        end
      end
      if (req_valid_i && req_ready_i) begin
        apply_request(req_user_i, req_data_i, predicted);
        awaited_q.push_back(predicted);
      end
      outstanding_o = awaited_q.size();
    end
  end

endmodule

### verif/double_ended_queue_core_test.sv
// Testbench top for double_ended_queue_core: drives directed and random
// requests under varying idle and stall patterns and reports the verdict.
// Depends on deq_pkg, double_ended_queue_core and double_ended_queue_checker.
module double_ended_queue_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import deq_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata = '0;
  logic [1:0]   s_tuser = CmdPushBack;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic [1:0]   m_tuser;

  int mismatches;
  int outstanding;
  int idle_pct = 0;
  int stall_pct = 0;
  logic hold_req = 1'b0;
  int hold_left = 0;

  int idle_by_phase[4]  = '{0, 65, 0, 32};
  int stall_by_phase[4] = '{0, 0, 65, 32};

  double_ended_queue_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  double_ended_queue_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_valid_i   (s_tvalid),
    .req_ready_i   (s_tready),
    .req_data_i    (s_tdata),
    .req_user_i    (s_tuser),
    .rsp_valid_i   (m_tvalid),
    .rsp_ready_i   (m_tready),
    .rsp_data_i    (m_tdata),
    .rsp_user_i    (m_tuser),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // A long hold-off lets the block back up and stall its request side.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (hold_req) begin
      hold_left <= 300;
      hold_req <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic offer(input logic [1:0] cmd, input logic [31:0] word);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= word;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic run_burst(input int push_pct, input int len);
    logic [1:0] cmd;
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(0, 99) < push_pct) begin
        cmd = $urandom_range(0, 1) ? CmdPushFront : CmdPushBack;
      end else begin
        cmd = $urandom_range(0, 1) ? CmdPopFront : CmdPopBack;
      end
      offer(cmd, rand_word());
    end
  endtask

  initial begin
    int done;
    int len;
    int push_pct;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pops on an empty queue, then both ends with extreme words.
    offer(CmdPopBack, 32'h1234_5678);
    offer(CmdPopFront, 32'hFFFF_FFFF);
    offer(CmdPushBack, 32'h7FFF_FFFF);
    offer(CmdPushFront, 32'h8000_0000);
    offer(CmdPushBack, 32'hFFFF_FFFF);
    offer(CmdPushFront, 32'h0000_0000);
    offer(CmdPopFront, 32'hDEAD_BEEF);
    offer(CmdPopBack, 32'h0000_0000);
    offer(CmdPopBack, 32'hFFFF_FFFF);
    offer(CmdPopFront, 32'h0000_0001);
    offer(CmdPopFront, 32'h0000_0000);
    offer(CmdPushFront, 32'h5555_5555);
    offer(CmdPopBack, 32'h0000_0000);
    offer(CmdPushBack, 32'hAAAA_AAAA);
    offer(CmdPopFront, 32'h0000_0000);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      done = 0;
      if (ph == 0) begin
        // Hold off the response side, then fill past full and empty past zero.
        hold_req <= 1'b1;
        run_burst(100, 70);
        run_burst(0, 70);
        done = 140;
      end
      while (done < 400) begin
        len = $urandom_range(8, 80);
        case ($urandom_range(0, 4))
          0: push_pct = 100;
          1: push_pct = 80;
          2: push_pct = 50;
          3: push_pct = 20;
          default: push_pct = 0;
        endcase
        run_burst(push_pct, len);
        done += len;
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
rtl/deq_pkg.sv
rtl/double_ended_queue_core.sv
verif/double_ended_queue_checker.sv
verif/double_ended_queue_core_test.sv
